FILE: design/sos_pkg.sv
package sos_pkg;

    // Ring size and derived address width
    localparam int SITES  = 256;
    localparam int ADDR_W = $clog2(SITES);

    localparam int H_W     = 10;
    localparam int BETA_W  = 16;
    localparam int DRIVE_W = 16;
    localparam int NL_W    = 20;
    localparam int SITE_W  = 8;
    localparam int SITE_N  = 1 << SITE_W;
    localparam int SOS_W   = 17;
    localparam int PROD_W  = SOS_W + BETA_W + 1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [H_W-1:0]    t_height;

    // Item modes
    localparam logic [1:0] MODE_MOVE  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BETA  = 2'd0;
    localparam logic [1:0] CFG_DRIVE = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    localparam logic [BETA_W-1:0]  BETA_RST  = 16'd4096;
    localparam logic [DRIVE_W-1:0] DRIVE_RST = 16'd0;
    localparam logic [H_W-1:0]     LIMIT_RST = 10'd800;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SITE_W-1:0] site;
        logic              direction;
        logic [NL_W-1:0]   neglog_uniform;
        logic [H_W-1:0]    height_value;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic signed [3:0] energy_delta;
        logic [H_W-1:0]    height_read;
    } t_out_item;

    // Height RAM address and write data sources
    typedef enum logic [2:0] {
        A_N, A_X, A_XP, A_NP, A_CLR
    } t_asel;

    typedef enum logic [1:0] {
        W_ZERO, W_HV, W_INC, W_DEC
    } t_wsel;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE,
        S_M_RN, S_M_RX, S_M_RXP, S_M_RNP, S_M_CAP, S_M_ENE, S_M_MUL, S_M_DEC, S_M_WR2,
        S_R_RX, S_R_CAP, S_W_WR, S_DONE
    } t_state;

    typedef struct packed {
        logic  load_item;
        logic  cap_n;
        logic  cap_x;
        logic  cap_xp;
        logic  cap_np;
        logic  calc;
        logic  mult;
        logic  decide;
        logic  load_res;
        logic  clr_step;
        logic  ram_we;
        t_asel asel;
        t_wsel wsel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       reject;
        logic       below;
        logic       out_free;
        logic       clr_last;
    } t_sts;

    // site modulo ring size, worked out at elaboration
    typedef t_addr t_mod_tbl [SITE_N];

    function automatic t_mod_tbl build_site_mod();
        t_mod_tbl tbl;
        for (int i = 0; i < SITE_N; i++) begin
            tbl[i] = t_addr'(i % SITES);
        end
        return tbl;
    endfunction

    localparam t_mod_tbl SITE_MOD = build_site_mod();

endpackage

FILE: design/sos_ram.sv
module sos_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/sos_ctrl.sv
module sos_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sos_pkg::t_sts i_sts,
    output sos_pkg::t_cmd o_cmd
);
    import sos_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.asel = A_X;
        cmd.wsel = W_ZERO;
        case (r_state)
            S_CLEAR: begin
                cmd.ram_we   = 1'b1;
                cmd.asel     = A_CLR;
                cmd.wsel     = W_ZERO;
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    n_state = S_DONE;
                    case (i_sts.mode)
                        MODE_MOVE:  n_state = S_M_RN;
                        MODE_WRITE: n_state = S_W_WR;
                        MODE_READ:  n_state = S_R_RX;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            // four reads, each captured in the state after the one that sets its address
            S_M_RN: begin
                cmd.asel = A_N;
                n_state  = S_M_RX;
            end
            S_M_RX: begin
                cmd.asel  = A_X;
                cmd.cap_n = 1'b1;
                n_state   = S_M_RXP;
            end
            S_M_RXP: begin
                cmd.asel  = A_XP;
                cmd.cap_x = 1'b1;
                n_state   = S_M_RNP;
            end
            S_M_RNP: begin
                cmd.asel   = A_NP;
                cmd.cap_xp = 1'b1;
                n_state    = S_M_CAP;
            end
            S_M_CAP: begin
                cmd.cap_np = 1'b1;
                n_state    = S_M_ENE;
            end
            S_M_ENE: begin
                cmd.calc = 1'b1;
                n_state  = S_M_MUL;
            end
            S_M_MUL: begin
                cmd.mult = 1'b1;
                n_state  = S_M_DEC;
            end
            S_M_DEC: begin
                cmd.decide = 1'b1;
                if (!i_sts.reject && i_sts.below) begin
                    cmd.ram_we = 1'b1;
                    cmd.asel   = A_X;
                    cmd.wsel   = W_INC;
                    n_state    = S_M_WR2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_M_WR2: begin
                cmd.ram_we = 1'b1;
                cmd.asel   = A_XP;
                cmd.wsel   = W_DEC;
                n_state    = S_DONE;
            end
            S_R_RX: begin
                cmd.asel = A_X;
                n_state  = S_R_CAP;
            end
            S_R_CAP: begin
                cmd.cap_x = 1'b1;
                n_state   = S_DONE;
            end
            S_W_WR: begin
                cmd.ram_we = 1'b1;
                cmd.asel   = A_X;
                cmd.wsel   = W_HV;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.load_res = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

`ifndef SYNTHESIS
    // an accepted move always writes its source right after its target
    a_wr_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.ram_we && cmd.wsel == W_INC) |=> (cmd.ram_we && cmd.wsel == W_DEC))
        else $error("move write pair broken");

    // a result is only loaded into a free output register
    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_res |-> i_sts.out_free)
        else $error("result overwrites pending item");

    // an accepted item always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted item not started");

    // no height write while idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !cmd.ram_we)
        else $error("height write while idle");
`endif

endmodule

FILE: design/sos_dp.sv
module sos_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  sos_pkg::t_in_item   i_in,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output sos_pkg::t_out_item  o_out,
    input  sos_pkg::t_cmd       i_cmd,
    output sos_pkg::t_sts       o_sts
);
    import sos_pkg::*;

    // configuration
    logic [BETA_W-1:0]  r_beta;
    logic [DRIVE_W-1:0] r_drive;
    logic [H_W-1:0]     r_limit;

    // item and working registers
    t_in_item                 r_item;
    t_addr                    r_x, r_xp, r_xn, r_np;
    t_height                  r_hn, r_hx, r_hxp, r_hnp;
    logic signed [3:0]        r_ene;
    logic signed [SOS_W-1:0]  r_sos;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_reject;
    logic                     r_acc;
    t_addr                    r_clr_addr;
    t_out_item                r_out;
    t_out_item                n_out;
    logic                     r_out_valid;

    t_addr   x, xp, xn, np;
    t_addr   ram_addr;
    t_height ram_wdata, ram_rdata;

    logic signed [13:0]        ene_sum;
    logic signed [SOS_W-1:0]   sos;
    logic signed [SOS_W-1:0]   drive_ext;
    logic                      reject;
    logic                      below;
    logic                      out_free;

    function automatic t_addr inc_site(t_addr a);
        return (a == t_addr'(SITES - 1)) ? '0 : a + t_addr'(1);
    endfunction

    function automatic t_addr dec_site(t_addr a);
        return (a == '0) ? t_addr'(SITES - 1) : a - t_addr'(1);
    endfunction

    function automatic logic signed [13:0] abs12(logic signed [11:0] v);
        logic signed [11:0] m;
        m = v[11] ? -v : v;
        return 14'(m);
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta  <= BETA_RST;
            r_drive <= DRIVE_RST;
            r_limit <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BETA:  r_beta  <= i_cfg_data;
                CFG_DRIVE: r_drive <= i_cfg_data;
                CFG_LIMIT: r_limit <= i_cfg_data[H_W-1:0];
                default:   ;
            endcase
        end
    end

    // neighbor addresses on the ring
    always_comb begin
        x  = SITE_MOD[i_in.site];
        xp = i_in.direction ? inc_site(x) : dec_site(x);
        xn = i_in.direction ? dec_site(x) : inc_site(x);
        np = i_in.direction ? inc_site(xp) : dec_site(xp);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in;
            r_x    <= x;
            r_xp   <= xp;
            r_xn   <= xn;
            r_np   <= np;
        end
        if (i_cmd.cap_n)  r_hn  <= ram_rdata;
        if (i_cmd.cap_x)  r_hx  <= ram_rdata;
        if (i_cmd.cap_xp) r_hxp <= ram_rdata;
        if (i_cmd.cap_np) r_hnp <= ram_rdata;
    end

    // clear sweep pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + t_addr'(1);
        end
    end

    // height RAM port
    always_comb begin
        case (i_cmd.asel)
            A_N:     ram_addr = r_xn;
            A_X:     ram_addr = r_x;
            A_XP:    ram_addr = r_xp;
            A_NP:    ram_addr = r_np;
            A_CLR:   ram_addr = r_clr_addr;
            default: ram_addr = r_x;
        endcase
        case (i_cmd.wsel)
            W_ZERO:  ram_wdata = '0;
            W_HV:    ram_wdata = r_item.height_value;
            W_INC:   ram_wdata = r_hx + t_height'(1);
            W_DEC:   ram_wdata = r_hxp - t_height'(1);
            default: ram_wdata = '0;
        endcase
    end

    sos_ram #(
        .WIDTH (H_W),
        .DEPTH (SITES)
    ) u_heights (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // bond energy change, drive term and bounds check
    always_comb begin
        logic signed [11:0] hn, hx, hxp, hnp;
        hn  = $signed({2'b00, r_hn});
        hx  = $signed({2'b00, r_hx});
        hxp = $signed({2'b00, r_hxp});
        hnp = $signed({2'b00, r_hnp});
        ene_sum = abs12(hx + 12'sd1 - hn) + abs12(hx - hxp + 12'sd2)
                + abs12(hxp - 12'sd1 - hnp)
                - abs12(hx - hn) - abs12(hx - hxp) - abs12(hxp - hnp);
        drive_ext = SOS_W'($signed(r_drive));
        sos = $signed({{(SOS_W - 16){ene_sum[3]}}, ene_sum[3:0], 12'b0})
            + (r_item.direction ? drive_ext : -drive_ext);
        reject = ({1'b0, r_hx} + 11'd1 >= {1'b0, r_limit}) || (r_hxp == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_ene    <= ene_sum[3:0];
            r_sos    <= sos;
            r_reject <= reject;
        end
        if (i_cmd.mult) begin
            r_prod <= PROD_W'($signed({1'b0, r_beta})) * PROD_W'(r_sos);
        end
        if (i_cmd.decide) begin
            r_acc <= !r_reject && below;
        end
    end

    // Metropolis test against -ln(u) scaled to Q8.24
    assign below = r_prod < $signed({2'b00, r_item.neglog_uniform, 12'b0});

    // output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result fields by mode
    always_comb begin
        n_out = '0;
        if (r_item.mode == MODE_MOVE && r_acc) begin
            n_out.accepted     = 1'b1;
            n_out.energy_delta = r_ene;
        end
        if (r_item.mode == MODE_READ) begin
            n_out.height_read = r_hx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        o_sts          = '0;
        o_sts.mode     = i_in.mode;
        o_sts.reject   = r_reject;
        o_sts.below    = below;
        o_sts.out_free = out_free;
        o_sts.clr_last = (r_clr_addr == t_addr'(SITES - 1));
    end

endmodule

FILE: design/sos_kawasaki_metropolis_step.sv
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in  (t_in_item)
// out       output     o_out_valid / i_out_stall o_out (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item at a time through a single-port height RAM with registered read.
// A move does four RAM reads, then energy, multiply and test, and two RAM
// writes when accepted; a read does one RAM read and a write one RAM write.
// After reset a clearing pass writes zero to all 256 heights, with o_in_stall
// high; configuration writes are taken at any time.
// A finished item waits in the output register under i_out_stall.
module sos_kawasaki_metropolis_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sos_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sos_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import sos_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    sos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sos_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

FILE: dv/sos_kawasaki_metropolis_step_tb.sv
`timescale 1ns / 1ps

module sos_kawasaki_metropolis_step_tb;

    import sos_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    sos_kawasaki_metropolis_step DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow of the ring and its registers
    logic [H_W-1:0] ring_h [SITES];
    int beta_q;
    int drive_q;
    int limit_q;

    t_out_item pending_results [$];
    int mismatch_count;
    int burst_left;
    int quiet_cycles;
    bit hold_pending;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int abs_i(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // One step of the ring: updates the shadow state, returns the expected item
    function automatic t_out_item kawasaki_step(input t_in_item it);
        t_out_item r;
        int x, s, ixp, inp, ineb;
        int hn, hx, hxp, hnp, ene;
        longint sos;
        r = '0;
        x = int'(it.site) % SITES;
        case (it.mode)
            MODE_WRITE: ring_h[x] = it.height_value;
            MODE_READ:  r.height_read = ring_h[x];
            MODE_MOVE: begin
                s    = it.direction ? 1 : -1;
                ixp  = (x + s + SITES) % SITES;
                inp  = (x + 2 * s + 2 * SITES) % SITES;
                ineb = (x - s + SITES) % SITES;
                hn   = int'(ring_h[ineb]);
                hx   = int'(ring_h[x]);
                hxp  = int'(ring_h[ixp]);
                hnp  = int'(ring_h[inp]);
                if (hx + 1 < limit_q && hxp != 0) begin
                    ene = abs_i(hx + 1 - hn) + abs_i(hx - hxp + 2) + abs_i(hxp - 1 - hnp)
                        - abs_i(hx - hn) - abs_i(hx - hxp) - abs_i(hxp - hnp);
                    sos = longint'(ene) * 4096 + longint'(s) * longint'(drive_q);
                    if (longint'(beta_q) * sos < longint'(it.neglog_uniform) * 4096) begin
                        ring_h[x]   = H_W'(hx + 1);
                        ring_h[ixp] = H_W'(hxp - 1);
                        r.accepted     = 1'b1;
                        r.energy_delta = 4'(ene);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_in_item mk_item(input logic [1:0] mode, input int site,
                                         input bit dir, input int nl, input int hv);
        t_in_item it;
        it.mode           = mode;
        it.site           = SITE_W'(site);
        it.direction      = dir;
        it.neglog_uniform = NL_W'(nl);
        it.height_value   = H_W'(hv);
        return it;
    endfunction

    // Fully random item; -ln(u) mostly in the range where the test is decided
    function automatic t_in_item rand_item();
        t_in_item it;
        it.mode      = 2'($urandom_range(0, 3));
        it.site      = SITE_W'($urandom);
        it.direction = 1'($urandom);
        if ($urandom_range(0, 99) < 70) begin
            it.neglog_uniform = NL_W'($urandom_range(0, 12288));
        end else begin
            it.neglog_uniform = NL_W'($urandom);
        end
        it.height_value = H_W'($urandom);
        return it;
    endfunction

    // Send one item; the sender runs in bursts with gaps in between
    task automatic send_item(input t_in_item it);
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            if ($urandom_range(0, 9) == 0) begin
                burst_left = $urandom_range(40, 120);
            end else begin
                burst_left = $urandom_range(1, 12);
            end
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(kawasaki_step(it));
        burst_left--;
    endtask

    // Stop offering items and wait until every result is out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Register writes keep valid high across the batch and drop it at the end
    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BETA:  beta_q  = int'(data);
            CFG_DRIVE: drive_q = int'($signed(data));
            CFG_LIMIT: limit_q = int'(data[H_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic set_regs(input int beta, input int drive, input int limit);
        wait_idle();
        cfg_write(CFG_BETA, 16'(beta));
        cfg_write(CFG_DRIVE, 16'(drive));
        // upper bits of the limit word are don't care
        cfg_write(CFG_LIMIT, {6'($urandom), H_W'(limit)});
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly moves around a small prepared patch of the ring
    task automatic run_random(input int n_items);
        int sent, base, pick, h0;
        t_in_item it;
        sent = 0;
        base = $urandom_range(0, SITES - 1);
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 8 || sent == 0) begin
                base = $urandom_range(0, SITES - 1);
                if (limit_q > 12 && $urandom_range(0, 9) < 8) begin
                    h0 = $urandom_range(1, limit_q - 10);
                end else begin
                    h0 = $urandom_range(0, 1023);
                end
                for (int k = 0; k < 6; k++) begin
                    it = rand_item();
                    it.mode         = MODE_WRITE;
                    it.site         = SITE_W'(base + k);
                    it.height_value = H_W'(h0 + $urandom_range(0, 3));
                    send_item(it);
                    sent++;
                end
            end else begin
                it = rand_item();
                if (pick < 75) begin
                    it.mode = MODE_MOVE;
                    it.site = SITE_W'(base + $urandom_range(0, 5));
                end else if (pick < 85) begin
                    it.mode = MODE_READ;
                    it.site = SITE_W'(base + $urandom_range(0, 5));
                end else if (pick < 90) begin
                    it.mode = MODE_UNUSED;
                end
                send_item(it);
                sent++;
            end
        end
    endtask

    // Corners: reset heights, ring wrap, bounds rejects, unused mode
    task automatic test_directed();
        send_item(mk_item(MODE_READ, 0, 1'b0, 0, 0));
        send_item(mk_item(MODE_WRITE, 0, 1'b0, 0, 5));
        send_item(mk_item(MODE_WRITE, 1, 1'b1, 0, 3));
        send_item(mk_item(MODE_WRITE, 255, 1'b0, 0, 7));
        send_item(mk_item(MODE_WRITE, 254, 1'b1, 0, 1));
        send_item(mk_item(MODE_WRITE, 2, 1'b0, 0, 9));
        send_item(mk_item(MODE_READ, 255, 1'b1, 'hFFFFF, 'h3FF));
        send_item(mk_item(MODE_MOVE, 0, 1'b0, 'hFFFFF, 0));
        send_item(mk_item(MODE_MOVE, 255, 1'b1, 0, 'h3FF));
        // neighbor at zero height
        send_item(mk_item(MODE_MOVE, 10, 1'b1, 'hFFFFF, 0));
        send_item(mk_item(MODE_UNUSED, 255, 1'b1, 'hFFFFF, 'h3FF));
        // stored above the limit, then a move from it
        send_item(mk_item(MODE_WRITE, 20, 1'b0, 0, 1023));
        send_item(mk_item(MODE_WRITE, 21, 1'b0, 0, 4));
        send_item(mk_item(MODE_READ, 20, 1'b0, 0, 0));
        send_item(mk_item(MODE_MOVE, 20, 1'b1, 'hFFFFF, 0));
        // target just reaching the limit, then just below it
        send_item(mk_item(MODE_WRITE, 30, 1'b0, 0, 799));
        send_item(mk_item(MODE_WRITE, 31, 1'b0, 0, 5));
        send_item(mk_item(MODE_MOVE, 30, 1'b1, 'hFFFFF, 0));
        send_item(mk_item(MODE_WRITE, 40, 1'b0, 0, 798));
        send_item(mk_item(MODE_WRITE, 41, 1'b0, 0, 5));
        send_item(mk_item(MODE_MOVE, 40, 1'b1, 'hFFFFF, 0));
        send_item(mk_item(MODE_READ, 40, 1'b0, 0, 0));
        send_item(mk_item(MODE_READ, 41, 1'b0, 0, 0));
    endtask

    // Register sweep including the extremes and a zero height limit
    task automatic test_config_sweep();
        int betas  [8] = '{4096, 0, 65535, 1, 65535, 2048, 40000, 4096};
        int drives [8] = '{0, 0, -32768, 32767, 32767, -4096, 12345, -1};
        int limits [8] = '{800, 800, 1023, 1, 50, 0, 6, 800};
        for (int p = 0; p < 8; p++) begin
            set_regs(betas[p], drives[p], limits[p]);
            run_random(130);
        end
    endtask

    // Output held off for a long stretch while items keep coming
    task automatic test_backpressure();
        t_in_item it;
        set_regs(4096, 0, 800);
        for (int k = 0; k < 6; k++) begin
            send_item(mk_item(MODE_WRITE, 100 + k, 1'b0, 0, 10 + $urandom_range(0, 3)));
        end
        wait_idle();
        hold_pending = 1'b1;
        burst_left   = 1000;
        for (int k = 0; k < 24; k++) begin
            it = rand_item();
            it.mode = (k % 4 == 3) ? MODE_READ : MODE_MOVE;
            it.site = SITE_W'(100 + $urandom_range(0, 5));
            send_item(it);
        end
        burst_left = 0;
    endtask

    // Receiver stall: random patterns per segment, plus the long hold
    initial begin : out_stall_gen
        int seg_left, pattern, period, phase;
        i_out_stall <= 1'b0;
        seg_left = 0;
        pattern  = 0;
        period   = 1;
        phase    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_pending = 1'b0;
            end else begin
                if (seg_left <= 0) begin
                    seg_left = $urandom_range(20, 200);
                    pattern  = $urandom_range(0, 3);
                    period   = $urandom_range(2, 7);
                end
                seg_left--;
                phase++;
                case (pattern)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ((phase % period) == 0);
                endcase
            end
        end
    end

    // Compare each result with the oldest expected item
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result: acc=%0d ene=%0d h=%0d",
                             o_out.accepted, o_out.energy_delta, o_out.height_read);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_out.accepted !== want.accepted
                    || o_out.energy_delta !== want.energy_delta
                    || o_out.height_read !== want.height_read) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch: exp acc=%0d ene=%0d h=%0d, got acc=%0d ene=%0d h=%0d",
                                 want.accepted, want.energy_delta, want.height_read,
                                 o_out.accepted, o_out.energy_delta, o_out.height_read);
                    end
                end
            end
        end
    end

    // Ends the run when no channel has moved for too long
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : main_seq
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_BETA;
        i_cfg_data  <= '0;
        beta_q  = int'(BETA_RST);
        drive_q = int'($signed(DRIVE_RST));
        limit_q = int'(LIMIT_RST);
        for (int k = 0; k < SITES; k++) ring_h[k] = '0;
        mismatch_count = 0;
        burst_left     = 0;
        quiet_cycles   = 0;
        hold_pending   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_config_sweep();
        test_backpressure();

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
